// ===== sv/sske_pkg.sv =====
// Package with the item types, type codes and status codes of the sort key encoder.
package sske_pkg;

    localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
    localparam logic [31:0] SIGN32 = 32'h8000_0000;

    localparam logic [7:0] MARK_FIRST = 8'h00;
    localparam logic [7:0] MARK_VALUE = 8'h01;
    localparam logic [7:0] MARK_LAST  = 8'h02;

    localparam int unsigned KEY_BYTES  = 13;
    localparam int unsigned BODY_BYTES = 12;

    typedef logic [1:0] t_status;
    localparam t_status STATUS_OK          = 2'd0;
    localparam t_status STATUS_NO_ROOM     = 2'd1;
    localparam t_status STATUS_UNSUPPORTED = 2'd2;

    typedef logic [3:0] t_func;
    localparam t_func FUNC_INT8      = 4'd0;
    localparam t_func FUNC_INT16     = 4'd1;
    localparam t_func FUNC_INT32     = 4'd2;
    localparam t_func FUNC_INT64     = 4'd3;
    localparam t_func FUNC_UINT8     = 4'd4;
    localparam t_func FUNC_UINT16    = 4'd5;
    localparam t_func FUNC_UINT32    = 4'd6;
    localparam t_func FUNC_UINT64    = 4'd7;
    localparam t_func FUNC_FLOAT     = 4'd8;
    localparam t_func FUNC_DOUBLE    = 4'd9;
    localparam t_func FUNC_TIMESTAMP = 4'd10;
    localparam t_func FUNC_INTERVAL  = 4'd11;

    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_NULLABLE    = 2'd0;
    localparam t_cfg_index CFG_NULLS_FIRST = 2'd1;
    localparam t_cfg_index CFG_ASCENDING   = 2'd2;

    typedef struct packed {
        logic [3:0]  func;
        logic [63:0] value;
        logic [31:0] value_extra;
        logic        is_null;
        logic [7:0]  room;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  key_len;
        logic [63:0] key_word0;
        logic [39:0] key_word1;
    } t_out_item;

endpackage

// ===== sv/sske_if.sv =====
// Handshake interfaces for the item streams and the configuration write channel.
interface sske_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sske_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic       data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/scalar_sort_key_encoder_core.sv =====
// Top level of the sort key encoder: a three-stage pipeline from typed scalar to byte key.
//
// The block takes one item per clock while the output is not stalled and returns one key
// item for each, in order. A result passes through the decode, encode and assembly stages,
// which each hold one register. Every stage carries its own valid bit and moves on when the
// stage after it is empty or moving, so a stall at the output fills the bubbles in front
// of it before input is held off. Configuration writes are taken in any cycle and should
// only be made while no item is in flight.
module scalar_sort_key_encoder_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sske_stream_if.sink          i_item,
    sske_stream_if.source        o_key,
    sske_cfg_if.sink             i_cfg
);
    import sske_pkg::*;

    typedef enum logic [2:0] {
        K_INT, K_UINT, K_FLOAT, K_DOUBLE, K_TS, K_INTV, K_NONE
    } t_kind;

    typedef enum logic [1:0] {W_1, W_2, W_4, W_8} t_wcode;

    typedef struct packed {
        t_status     status;
        logic [3:0]  len;
        logic        marker_only;
        logic        marker_en;
        logic [7:0]  marker;
        logic        asc;
        logic [3:0]  nbody;
        t_kind       kind;
        t_wcode      wcode;
        logic [63:0] value;
        logic [31:0] extra;
    } t_sa;

    typedef struct packed {
        t_status     status;
        logic [3:0]  len;
        logic        marker_only;
        logic        marker_en;
        logic [7:0]  marker;
        logic        asc;
        logic [3:0]  nbody;
        logic [95:0] body;
    } t_sb;

    logic      r_nullable;
    logic      r_nulls_first;
    logic      r_ascending;

    logic      r_va;
    logic      r_vb;
    logic      r_vc;
    t_sa       r_a;
    t_sa       n_a;
    t_sb       r_b;
    t_sb       n_b;
    t_out_item r_c;
    t_out_item n_c;

    logic      ready_a;
    logic      ready_b;
    logic      ready_c;

    assign ready_c      = !r_vc || o_key.ready;
    assign ready_b      = !r_vb || ready_c;
    assign ready_a      = !r_va || ready_b;
    assign i_item.ready = ready_a;
    assign o_key.valid  = r_vc;
    assign o_key.data   = r_c;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nullable    <= 1'b1;
            r_nulls_first <= 1'b1;
            r_ascending   <= 1'b1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_NULLABLE:    r_nullable    <= i_cfg.data;
                CFG_NULLS_FIRST: r_nulls_first <= i_cfg.data;
                CFG_ASCENDING:   r_ascending   <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // Decode stage: type, body length, room check and null marker.
    always_comb begin
        t_in_item   it;
        logic [3:0] total;
        it    = i_item.data;
        n_a   = '0;
        n_a.value = it.value;
        n_a.extra = it.value_extra;
        n_a.asc   = r_ascending;
        n_a.marker_en = r_nullable;
        n_a.wcode = t_wcode'(it.func[1:0]);
        n_a.kind  = K_NONE;
        unique case (it.func)
            FUNC_INT8, FUNC_INT16, FUNC_INT32, FUNC_INT64: begin
                n_a.kind  = K_INT;
                n_a.nbody = 4'd1 << it.func[1:0];
            end
            FUNC_UINT8, FUNC_UINT16, FUNC_UINT32, FUNC_UINT64: begin
                n_a.kind  = K_UINT;
                n_a.nbody = 4'd1 << it.func[1:0];
            end
            FUNC_FLOAT: begin
                n_a.kind  = K_FLOAT;
                n_a.wcode = W_4;
                n_a.nbody = 4'd4;
            end
            FUNC_DOUBLE: begin
                n_a.kind  = K_DOUBLE;
                n_a.wcode = W_8;
                n_a.nbody = 4'd8;
            end
            FUNC_TIMESTAMP: begin
                n_a.kind  = K_TS;
                n_a.wcode = W_8;
                n_a.nbody = 4'd10;
            end
            FUNC_INTERVAL: begin
                n_a.kind  = K_INTV;
                n_a.wcode = W_8;
                n_a.nbody = 4'd12;
            end
            default: begin
                n_a.kind  = K_NONE;
                n_a.nbody = 4'd0;
            end
        endcase
        total      = {3'b000, r_nullable} + n_a.nbody;
        n_a.marker = MARK_VALUE;
        if (it.room == 8'd0) begin
            n_a.status = STATUS_NO_ROOM;
        end else if (r_nullable && it.is_null) begin
            n_a.status      = STATUS_OK;
            n_a.len         = 4'd1;
            n_a.marker_only = 1'b1;
            n_a.marker      = r_nulls_first ? MARK_FIRST : MARK_LAST;
        end else if (n_a.kind == K_NONE) begin
            n_a.status = STATUS_UNSUPPORTED;
        end else if ({4'b0000, total} > it.room) begin
            n_a.status = STATUS_NO_ROOM;
        end else begin
            n_a.status = STATUS_OK;
            n_a.len    = total;
        end
    end

    // Encode stage: order-preserving transform and left justification of the body.
    always_comb begin
        logic [63:0] main;
        logic [63:0] lj;
        logic [31:0] tail;
        logic [31:0] f32;
        logic [63:0] f64;
        main = '0;
        tail = '0;
        f32  = (r_a.value[31:0] == SIGN32) ? 32'd0 : r_a.value[31:0];
        f64  = (r_a.value == SIGN64) ? 64'd0 : r_a.value;
        unique case (r_a.kind)
            K_INT: begin
                unique case (r_a.wcode)
                    W_1: main = {56'd0, r_a.value[7:0] ^ 8'h80};
                    W_2: main = {48'd0, r_a.value[15:0] ^ 16'h8000};
                    W_4: main = {32'd0, r_a.value[31:0] ^ SIGN32};
                    W_8: main = r_a.value ^ SIGN64;
                    default: main = '0;
                endcase
            end
            K_UINT: main = r_a.value;
            K_FLOAT: main = {32'd0, f32[31] ? ~f32 : (f32 | SIGN32)};
            K_DOUBLE: main = f64[63] ? ~f64 : (f64 | SIGN64);
            K_TS: begin
                main = r_a.value ^ SIGN64;
                tail = {r_a.extra[15:0], 16'd0};
            end
            K_INTV: begin
                main = r_a.value ^ SIGN64;
                tail = r_a.extra ^ SIGN32;
            end
            default: main = '0;
        endcase
        unique case (r_a.wcode)
            W_1: lj = {main[7:0], 56'd0};
            W_2: lj = {main[15:0], 48'd0};
            W_4: lj = {main[31:0], 32'd0};
            W_8: lj = main;
            default: lj = main;
        endcase
        n_b.status      = r_a.status;
        n_b.len         = r_a.len;
        n_b.marker_only = r_a.marker_only;
        n_b.marker_en   = r_a.marker_en;
        n_b.marker      = r_a.marker;
        n_b.asc         = r_a.asc;
        n_b.nbody       = r_a.nbody;
        n_b.body        = {lj, tail};
    end

    // Assembly stage: descending inversion, marker placement and zeroing on error.
    always_comb begin
        logic [95:0]  mask;
        logic [95:0]  body;
        logic [103:0] key;
        for (int i = 0; i < BODY_BYTES; i++) begin
            mask[95 - 8*i -: 8] = (4'(i) < r_b.nbody) ? 8'hFF : 8'h00;
        end
        body = r_b.body ^ (r_b.asc ? 96'd0 : mask);
        if (r_b.status != STATUS_OK) begin
            key = '0;
        end else if (r_b.marker_only) begin
            key = {r_b.marker, 96'd0};
        end else if (r_b.marker_en) begin
            key = {r_b.marker, body};
        end else begin
            key = {body, 8'd0};
        end
        n_c.status    = r_b.status;
        n_c.key_len   = (r_b.status == STATUS_OK) ? r_b.len : 4'd0;
        n_c.key_word0 = key[103:40];
        n_c.key_word1 = key[39:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (ready_a) begin
                r_va <= i_item.valid;
            end
            if (ready_b) begin
                r_vb <= r_va;
            end
            if (ready_c) begin
                r_vc <= r_vb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a) begin
            r_a <= n_a;
        end
        if (ready_b) begin
            r_b <= n_b;
        end
        if (ready_c) begin
            r_c <= n_c;
        end
    end

endmodule
